// ----- rtl/pmpt_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared types, codes and constants for the packet tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pmpt_pkg;

  localparam int POS_BITS_DEFAULT = 16;
  localparam int POS_OUT_BITS     = 16;
  localparam int SIZE_BITS        = 13;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 13;
  localparam int CURSOR_RESET     = 100;

  localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
  localparam logic [7:0] HDR_OVF_MASK  = 8'hC0;
  localparam logic [7:0] HDR_BTN_MASK  = 8'h07;

  typedef enum logic [1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_POLL  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WHEEL_MODE    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_X      = 2'd1,
    ST_Y      = 2'd2,
    ST_WHEEL  = 2'd3
  } pkt_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } item_t;

  // Click latch order: bit0 left down, bit1 left up, bit2 right down, bit3 right up.
  typedef struct packed {
    logic [POS_OUT_BITS-1:0] pos_x;
    logic [POS_OUT_BITS-1:0] pos_y;
    logic [2:0]              button_bits;
    logic [3:0]              clicks;
    logic signed [7:0]       wheel_total;
    logic                    any_activity;
    logic                    packet_applied;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/pmpt_in_reg.sv -----
// ----------------------------------------------------------------------------
// Packet tracker input register
// Captures one input word and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmpt_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pmpt_pkg::item_t in_item,
  input  wire logic          take,
  output logic               held_valid,
  output pmpt_pkg::item_t    held_item
);
  import pmpt_pkg::*;

  logic   full;
  item_t  item;

  assign in_ready   = !full || take;
  assign held_valid = full;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pmpt_axis.sv -----
// ----------------------------------------------------------------------------
// Packet tracker axis update
// Adds a signed move to one cursor coordinate and clamps it to the range.
// ----------------------------------------------------------------------------
`default_nettype none

module pmpt_axis #(
  parameter int POS_BITS = pmpt_pkg::POS_BITS_DEFAULT
) (
  input  wire logic [POS_BITS-1:0]            cur,
  input  wire logic signed [8:0]              delta,
  input  wire logic [pmpt_pkg::SIZE_BITS-1:0] size,
  output logic [POS_BITS-1:0]                 nxt
);
  import pmpt_pkg::*;

  // Two spare bits cover both the sign and the carry of the sum.
  localparam int W = ((POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS) + 2;
  localparam logic signed [W-1:0] LIM = W'((64'd1 << POS_BITS) - 64'd1);

  logic signed [W-1:0] sum;
  logic signed [W-1:0] size_s;
  logic signed [W-1:0] clamped;

  always_comb begin
    sum    = $signed(W'(cur)) + W'(delta);
    size_s = $signed(W'(size));
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > LIM) begin
      clamped = LIM;
    end else begin
      clamped = sum;
    end
    // A screen size above the coordinate range never bites here.
    if (size != '0 && clamped >= size_s) begin
      clamped = size_s - W'(1);
    end
    nxt = clamped[POS_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/pmpt_out_reg.sv -----
// ----------------------------------------------------------------------------
// Packet tracker result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmpt_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire pmpt_pkg::result_t load_res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pmpt_pkg::result_t      res
);
  import pmpt_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ps2_mouse_packet_tracker_core.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Assembles mouse bytes into packets and tracks cursor, buttons and wheel.
// ----------------------------------------------------------------------------
// Each input word yields exactly one result word. The block takes one word
// per clock cycle while the output is not stalled: a word is captured in the
// input register, and once the result register is free the packet update (one
// add and clamp per axis) writes the tracker state and the result register.
// A stalled output only stops input once both registers are full. The
// configuration registers should be written only while no word is in flight.
`default_nettype none

module ps2_mouse_packet_tracker_core #(
  parameter int POS_BITS = pmpt_pkg::POS_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [pmpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pmpt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          func,
  input  wire logic [7:0]                          data_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [15:0]                              pos_x,
  output logic [15:0]                              pos_y,
  output logic [2:0]                               button_bits,
  output logic                                     left_down_seen,
  output logic                                     left_up_seen,
  output logic                                     right_down_seen,
  output logic                                     right_up_seen,
  output logic signed [7:0]                        wheel_total,
  output logic                                     any_activity,
  output logic                                     packet_applied
);
  import pmpt_pkg::*;

  localparam int OW = (POS_BITS > POS_OUT_BITS) ? POS_BITS : POS_OUT_BITS;

  // Configuration
  logic                 wheel_mode;
  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  // Tracker state
  pkt_state_t          pkt_state, pkt_state_next;
  logic [7:0]          header_byte, header_byte_next;
  logic [7:0]          x_move_byte, x_move_byte_next;
  logic [7:0]          y_move_byte, y_move_byte_next;
  logic [POS_BITS-1:0] cursor_x, cursor_x_next;
  logic [POS_BITS-1:0] cursor_y, cursor_y_next;
  logic [2:0]          held_buttons, held_buttons_next;
  logic [3:0]          click_latches, click_latches_next;
  logic [7:0]          wheel_sum, wheel_sum_next;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    fire;
  result_t res_next;
  result_t res;

  logic                apply;
  logic [7:0]          wheel_out;
  logic [2:0]          btn_now;
  logic signed [8:0]   dx;
  logic signed [8:0]   dy;
  logic [POS_BITS-1:0] ax_x;
  logic [POS_BITS-1:0] ax_y;
  logic [OW-1:0]       cx_ext;
  logic [OW-1:0]       cy_ext;

  assign in_item.func      = func;
  assign in_item.data_byte = data_byte;

  pmpt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (s1_valid),
    .held_item  (s1_item)
  );

  assign fire = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode    <= 1'b0;
      screen_width  <= '0;
      screen_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WHEEL_MODE:    wheel_mode    <= cfg_data[0];
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SIZE_BITS-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The Y move byte is used in the same cycle it arrives when it ends a packet.
  assign dx = $signed({x_move_byte[7], x_move_byte});
  assign dy = -$signed({y_move_byte_next[7], y_move_byte_next});

  pmpt_axis #(.POS_BITS(POS_BITS)) u_axis_x (
    .cur   (cursor_x),
    .delta (dx),
    .size  (screen_width),
    .nxt   (ax_x)
  );

  pmpt_axis #(.POS_BITS(POS_BITS)) u_axis_y (
    .cur   (cursor_y),
    .delta (dy),
    .size  (screen_height),
    .nxt   (ax_y)
  );

  assign btn_now = header_byte[2:0] & HDR_BTN_MASK[2:0];

  always_comb begin
    pkt_state_next     = pkt_state;
    header_byte_next   = header_byte;
    x_move_byte_next   = x_move_byte;
    y_move_byte_next   = y_move_byte;
    held_buttons_next  = held_buttons;
    click_latches_next = click_latches;
    wheel_sum_next     = wheel_sum;
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    apply              = 1'b0;

    if (s1_item.func == FUNC_DATA) begin
      unique case (pkt_state)
        ST_HEADER: begin
          if ((s1_item.data_byte & HDR_SYNC_MASK) != '0 &&
              (s1_item.data_byte & HDR_OVF_MASK) == '0) begin
            header_byte_next = s1_item.data_byte;
            pkt_state_next   = ST_X;
          end
        end
        ST_X: begin
          x_move_byte_next = s1_item.data_byte;
          pkt_state_next   = ST_Y;
        end
        ST_Y: begin
          y_move_byte_next = s1_item.data_byte;
          if (!wheel_mode) begin
            apply          = 1'b1;
            pkt_state_next = ST_HEADER;
          end else begin
            pkt_state_next = ST_WHEEL;
          end
        end
        ST_WHEEL: begin
          apply          = 1'b1;
          pkt_state_next = ST_HEADER;
          // A wheel byte only counts if wheel mode is still on at its arrival.
          if (wheel_mode) begin
            wheel_sum_next = wheel_sum + s1_item.data_byte;
          end
        end
        default: ;
      endcase
    end

    if (apply) begin
      held_buttons_next = btn_now;
      click_latches_next = click_latches |
                           {~btn_now[1] &  held_buttons[1],
                             btn_now[1] & ~held_buttons[1],
                            ~btn_now[0] &  held_buttons[0],
                             btn_now[0] & ~held_buttons[0]};
      cursor_x_next = ax_x;
      cursor_y_next = ax_y;
    end

    wheel_out = wheel_sum_next;

    case (s1_item.func)
      FUNC_POLL:  wheel_sum_next     = '0;
      FUNC_CLEAR: click_latches_next = '0;
      default: ;
    endcase

    cx_ext = OW'(cursor_x_next);
    cy_ext = OW'(cursor_y_next);

    res_next.pos_x          = cx_ext[POS_OUT_BITS-1:0];
    res_next.pos_y          = cy_ext[POS_OUT_BITS-1:0];
    res_next.button_bits    = held_buttons_next;
    res_next.clicks         = click_latches_next;
    res_next.wheel_total    = $signed(wheel_out);
    res_next.any_activity   = (held_buttons_next != '0) || click_latches_next[0] ||
                              click_latches_next[2] || (wheel_sum_next != '0);
    res_next.packet_applied = apply;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_state     <= ST_HEADER;
      cursor_x      <= POS_BITS'(CURSOR_RESET);
      cursor_y      <= POS_BITS'(CURSOR_RESET);
      held_buttons  <= '0;
      click_latches <= '0;
      wheel_sum     <= '0;
    end else if (fire) begin
      pkt_state     <= pkt_state_next;
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      held_buttons  <= held_buttons_next;
      click_latches <= click_latches_next;
      wheel_sum     <= wheel_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      header_byte <= header_byte_next;
      x_move_byte <= x_move_byte_next;
      y_move_byte <= y_move_byte_next;
    end
  end

  pmpt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_res  (res_next),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign pos_x           = res.pos_x;
  assign pos_y           = res.pos_y;
  assign button_bits     = res.button_bits;
  assign left_down_seen  = res.clicks[0];
  assign left_up_seen    = res.clicks[1];
  assign right_down_seen = res.clicks[2];
  assign right_up_seen   = res.clicks[3];
  assign wheel_total     = res.wheel_total;
  assign any_activity    = res.any_activity;
  assign packet_applied  = res.packet_applied;

`ifndef SYNTHESIS
  a_applied_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.packet_applied |=> pkt_state == ST_HEADER)
    else $error("packet completed but assembly did not restart");

  a_x_in_screen: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.packet_applied && screen_width != '0
    |=> cursor_x < $past(screen_width))
    else $error("cursor x outside the screen after a packet");

  a_y_in_screen: assert property (@(posedge clk) disable iff (rst)
    fire && res_next.packet_applied && screen_height != '0
    |=> cursor_y < $past(screen_height))
    else $error("cursor y outside the screen after a packet");

  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    fire && s1_item.func == FUNC_POLL |=> wheel_sum == '0)
    else $error("poll did not clear the wheel total");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Streams mouse bytes, polls and clears through the tracker with random gaps
// and output stalls, predicts every result word from its own copy of the
// cursor, button and wheel state, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
  import pmpt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         POS_LIMIT     = (1 << POS_BITS_DEFAULT) - 1;
  localparam logic [3:0] PRESS_LATCHES = 4'b0101;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PRINT_LIMIT   = 30;

  // Tracks cursor, buttons, click latches and wheel sum, and keeps the result
  // words that the block still owes.
  class mouse_tracker_scoreboard;
    logic        wheel_mode;
    logic [12:0] width_limit;
    logic [12:0] height_limit;
    pkt_state_t  byte_phase;
    logic [7:0]  header;
    logic [7:0]  x_move;
    logic [7:0]  y_move;
    int          cur_x;
    int          cur_y;
    logic [2:0]  held;
    logic [3:0]  clicks;
    logic [7:0]  wheel_acc;
    result_t     owed_words[$];
    int          mismatch_count;

    function new();
      wheel_mode     = 1'b0;
      width_limit    = '0;
      height_limit   = '0;
      byte_phase     = ST_HEADER;
      header         = '0;
      x_move         = '0;
      y_move         = '0;
      cur_x          = CURSOR_RESET;
      cur_y          = CURSOR_RESET;
      held           = '0;
      clicks         = '0;
      wheel_acc      = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [12:0] value);
      case (idx)
        CFG_WHEEL_MODE:    wheel_mode = value[0];
        CFG_SCREEN_WIDTH:  width_limit = value;
        CFG_SCREEN_HEIGHT: height_limit = value;
        default: ;
      endcase
    endfunction

    function int move_axis(int cur, int delta, logic [12:0] size);
      int p;
      p = cur + delta;
      if (p < 0) p = 0;
      if (p > POS_LIMIT) p = POS_LIMIT;
      if (size != 0 && p >= int'(size)) p = int'(size) - 1;
      return p;
    endfunction

    function void apply_packet(logic [7:0] wheel_byte, bit use_wheel);
      logic [2:0] prev;
      prev = held;
      held = header[2:0] & HDR_BTN_MASK[2:0];
      if (held[0] && !prev[0]) clicks[0] = 1'b1;
      if (!held[0] && prev[0]) clicks[1] = 1'b1;
      if (held[1] && !prev[1]) clicks[2] = 1'b1;
      if (!held[1] && prev[1]) clicks[3] = 1'b1;
      if (use_wheel) wheel_acc = wheel_acc + wheel_byte;
      cur_x = move_axis(cur_x, int'($signed(x_move)), width_limit);
      cur_y = move_axis(cur_y, -int'($signed(y_move)), height_limit);
    endfunction

    function void note_word(logic [1:0] f, logic [7:0] d);
      result_t    r;
      logic [7:0] wheel_before;
      bit         applied;
      applied = 1'b0;
      if (f == FUNC_DATA) begin
        case (byte_phase)
          ST_HEADER: begin
            if ((d & HDR_SYNC_MASK) != 0 && (d & HDR_OVF_MASK) == 0) begin
              header     = d;
              byte_phase = ST_X;
            end
          end
          ST_X: begin
            x_move     = d;
            byte_phase = ST_Y;
          end
          ST_Y: begin
            y_move = d;
            if (!wheel_mode) begin
              byte_phase = ST_HEADER;
              apply_packet(8'h00, 1'b0);
              applied = 1'b1;
            end else begin
              byte_phase = ST_WHEEL;
            end
          end
          default: begin
            // A fourth byte always ends the packet; its wheel value only
            // counts if wheel mode is still on.
            byte_phase = ST_HEADER;
            apply_packet(d, wheel_mode);
            applied = 1'b1;
          end
        endcase
      end
      wheel_before = wheel_acc;
      if (f == FUNC_POLL) wheel_acc = '0;
      else if (f == FUNC_CLEAR) clicks = '0;
      r.pos_x          = 16'(cur_x);
      r.pos_y          = 16'(cur_y);
      r.button_bits    = held;
      r.clicks         = clicks;
      r.wheel_total    = wheel_before;
      r.any_activity   = (held != 0) || ((clicks & PRESS_LATCHES) != 0) || (wheel_acc != 0);
      r.packet_applied = applied;
      owed_words.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    task check_word(result_t got);
      result_t want;
      if (owed_words.size() == 0) begin
        report_mismatch("result word with no expectation waiting");
      end else begin
        want = owed_words.pop_front();
        compare_field("pos_x", int'(got.pos_x), int'(want.pos_x));
        compare_field("pos_y", int'(got.pos_y), int'(want.pos_y));
        compare_field("button_bits", int'(got.button_bits), int'(want.button_bits));
        compare_field("left_down_seen", int'(got.clicks[0]), int'(want.clicks[0]));
        compare_field("left_up_seen", int'(got.clicks[1]), int'(want.clicks[1]));
        compare_field("right_down_seen", int'(got.clicks[2]), int'(want.clicks[2]));
        compare_field("right_up_seen", int'(got.clicks[3]), int'(want.clicks[3]));
        compare_field("wheel_total", int'(got.wheel_total), int'(want.wheel_total));
        compare_field("any_activity", int'(got.any_activity), int'(want.any_activity));
        compare_field("packet_applied", int'(got.packet_applied), int'(want.packet_applied));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                func;
  logic [7:0]                data_byte;
  logic                      out_valid;
  logic                      out_ready;
  logic [15:0]               pos_x;
  logic [15:0]               pos_y;
  logic [2:0]                button_bits;
  logic                      left_down_seen;
  logic                      left_up_seen;
  logic                      right_down_seen;
  logic                      right_up_seen;
  logic signed [7:0]         wheel_total;
  logic                      any_activity;
  logic                      packet_applied;

  mouse_tracker_scoreboard sb = new();
  result_t                 seen_word;
  bit                      wheel_now;
  int                      send_burst;
  int                      recv_burst;
  int                      cycle_count;

  ps2_mouse_packet_tracker_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .button_bits    (button_bits),
    .left_down_seen (left_down_seen),
    .left_up_seen   (left_up_seen),
    .right_down_seen(right_down_seen),
    .right_up_seen  (right_up_seen),
    .wheel_total    (wheel_total),
    .any_activity   (any_activity),
    .packet_applied (packet_applied)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(func, data_byte);
      if (out_valid && out_ready) begin
        seen_word.pos_x          = pos_x;
        seen_word.pos_y          = pos_y;
        seen_word.button_bits    = button_bits;
        seen_word.clicks         = {right_up_seen, right_down_seen, left_up_seen, left_down_seen};
        seen_word.wheel_total    = wheel_total;
        seen_word.any_activity   = any_activity;
        seen_word.packet_applied = packet_applied;
        sb.check_word(seen_word);
      end
    end
  end

  // Random gap lengths, with occasional runs of back-to-back words.
  function automatic int pick_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = int'($urandom_range(15, 50));
    return int'($urandom_range(0, 11));
  endfunction

  function automatic logic [7:0] pick_move();
    case ($urandom_range(0, 9))
      0:       return 8'h7F;
      1:       return 8'h80;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return 4096;
      default: return int'($urandom_range(2, 4095));
    endcase
  endfunction

  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    recv_burst = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap(recv_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [7:0] d);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                             input logic [7:0] dy, input logic [7:0] dw);
    send_item(FUNC_DATA, hdr);
    send_item(FUNC_DATA, dx);
    send_item(FUNC_DATA, dy);
    if (wheel_now) send_item(FUNC_DATA, dw);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(negedge clk);
  endtask

  task automatic put_register(input cfg_reg_t idx, input logic [12:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  // Registers may only change with nothing in flight, so drain first.
  task automatic apply_setting(input bit wm, input int w, input int h);
    wait_for_results();
    put_register(CFG_WHEEL_MODE, {12'd0, wm});
    put_register(CFG_SCREEN_WIDTH, 13'(w));
    put_register(CFG_SCREEN_HEIGHT, 13'(h));
    cfg_write <= 1'b0;
    wheel_now = wm;
  endtask

  // Mostly well-formed packets with random content; drift pushes the cursor
  // right and down hard enough to reach the upper clamps.
  task automatic stream_mixed(input int count, input bit drift);
    int         sent;
    int         r;
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
    sent = 0;
    while (sent < count) begin
      r = int'($urandom_range(0, 99));
      hdr = 8'($urandom);
      hdr[7:6] = 2'b00;
      hdr[3] = 1'b1;
      if (r < (drift ? 95 : 72)) begin
        if (drift) begin
          dx = 8'($urandom_range(120, 127));
          dy = 8'($urandom_range(128, 135));
        end else begin
          dx = pick_move();
          dy = pick_move();
        end
        send_packet(hdr, dx, dy, pick_move());
        sent += wheel_now ? 4 : 3;
      end else if (r < (drift ? 96 : 79)) begin
        send_item(FUNC_DATA, 8'($urandom));
        sent++;
      end else if (r < (drift ? 97 : 83)) begin
        // Packet cut short, so the next bytes land out of place.
        send_item(FUNC_DATA, hdr);
        send_item(FUNC_DATA, pick_move());
        sent += 2;
      end else if (r < (drift ? 98 : 90)) begin
        send_item(FUNC_POLL, 8'($urandom));
        sent++;
      end else if (r < (drift ? 99 : 97)) begin
        send_item(FUNC_CLEAR, 8'($urandom));
        sent++;
      end else begin
        send_item(FUNC_UNUSED, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : timeout
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** ps2_mouse_packet_tracker_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = CFG_WHEEL_MODE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    func       = FUNC_DATA;
    data_byte  = '0;
    wheel_now  = 1'b0;
    send_burst = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apply_setting(1'b0, 0, 0);

    // Idle poll, unknown function, and two rejected headers.
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_UNUSED, 8'hFF);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'hC8);
    // Left press while both axes clamp at zero, then left release and right
    // press with the largest moves the other way.
    send_packet(8'h09, 8'h80, 8'h7F, 8'h00);
    send_packet(8'h0E, 8'h7F, 8'h80, 8'h00);
    send_item(FUNC_CLEAR, 8'hA5);
    apply_setting(1'b1, 4096, 4096);
    send_packet(8'h2B, 8'h01, 8'hFF, 8'h7F);
    // Wheel mode switched off while the wheel byte is pending.
    send_item(FUNC_DATA, 8'h18);
    send_item(FUNC_DATA, 8'h05);
    send_item(FUNC_DATA, 8'h02);
    apply_setting(1'b0, 1, 1);
    send_item(FUNC_DATA, 8'h55);
    // Wheel mode switched on before the Y byte; the sum wraps past 127.
    send_item(FUNC_DATA, 8'h08);
    send_item(FUNC_DATA, 8'h10);
    apply_setting(1'b1, 0, 0);
    send_item(FUNC_DATA, 8'h20);
    send_item(FUNC_DATA, 8'h02);
    send_item(FUNC_POLL, 8'h5A);

    apply_setting(1'b1, 4096, 4096);
    stream_mixed(80, 1'b0);
    apply_setting(1'b0, 200, 150);
    stream_mixed(80, 1'b1);
    apply_setting(1'b1, 1, 1);
    stream_mixed(80, 1'b0);
    apply_setting(1'b0, 4096, 1);
    stream_mixed(80, 1'b0);
    apply_setting(1'b1, 0, 0);
    stream_mixed(80, 1'b0);
    repeat (2) begin
      apply_setting(1'($urandom), pick_size(), pick_size());
      stream_mixed(80, 1'b0);
    end
    // No screen size: drive both axes far past the largest screen, then drop
    // to the largest screen so the next moves clamp from far above it.
    apply_setting(1'b0, 0, 0);
    stream_mixed(720, 1'b1);
    apply_setting(1'b1, 4096, 4096);
    stream_mixed(150, 1'b0);

    wait_for_results();
    repeat (10) @(negedge clk);
    if (sb.owed_words.size() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.owed_words.size()));
    if (sb.mismatch_count == 0) begin
      $display("** ps2_mouse_packet_tracker_core: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule
